// ===== rtl/core/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg: shared types and helpers for the scheduled thermostat
// Holds register codes, field widths, the configuration and state records
// and the time window compare.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int TimeW  = 12;
	localparam int TempW  = 12;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int ByteW  = 8;
	localparam int IdxW   = 3;
	localparam int DataW  = 12;
	localparam int CmpW   = TempW + 2;

	localparam logic [TimeW-1:0] HOUR_SCALE = TimeW'(100);

	// Register indexes of the configuration channel.
	typedef enum logic [IdxW-1:0] {
		REG_QUIET_START     = 3'd0,
		REG_QUIET_END       = 3'd1,
		REG_LAMP_START      = 3'd2,
		REG_LAMP_END        = 3'd3,
		REG_COOL_SETPOINT   = 3'd4,
		REG_COOL_HYSTERESIS = 3'd5,
		REG_LOCKOUT_SECONDS = 3'd6
	} stc_reg_t;

	typedef struct packed {
		logic [TimeW-1:0]        quiet_start;
		logic [TimeW-1:0]        quiet_end;
		logic [TimeW-1:0]        lamp_start;
		logic [TimeW-1:0]        lamp_end;
		logic signed [TempW-1:0] cool_setpoint;
		logic [ByteW-1:0]        cool_hysteresis;
		logic [ByteW-1:0]        lockout_seconds;
	} stc_cfg_t;

	typedef struct packed {
		logic             cooler;
		logic             quiet;
		logic             light;
		logic [ByteW-1:0] lockout;
	} stc_state_t;

	typedef struct packed {
		logic                    is_sample;
		logic [TimeW-1:0]        now;
		logic signed [TempW-1:0] temp;
	} stc_item_t;

	// A window [s,e) wraps past midnight when s > e and is empty when s == e.
	function automatic logic in_window(logic [TimeW-1:0] s, logic [TimeW-1:0] e,
		logic [TimeW-1:0] t);
		logic res;
		if (s < e) begin
			res = (t >= s) && (t < e);
		end else if (s > e) begin
			res = (t >= s) || (t < e);
		end else begin
			res = 1'b0;
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/stc_ifs.sv =====
// ----------------------------------------------------------------------------
// stc_ifs: channel interfaces of the scheduled thermostat
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface stc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [stc_pkg::HourW-1:0]            hour_now;
	logic [stc_pkg::MinW-1:0]             minute_now;
	logic signed [stc_pkg::TempW-1:0]     temp_now;

	modport source (output valid, req_type, hour_now, minute_now, temp_now, input ready);
	modport sink   (input valid, req_type, hour_now, minute_now, temp_now, output ready);
endinterface

interface stc_res_if;
	logic valid;
	logic ready;
	logic quiet_active;
	logic cooler_on;
	logic light_on;

	modport source (output valid, quiet_active, cooler_on, light_on, input ready);
	modport sink   (input valid, quiet_active, cooler_on, light_on, output ready);
endinterface

interface stc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [stc_pkg::IdxW-1:0]    index;
	logic [stc_pkg::DataW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/stc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// stc_cfg_regs: configuration register file
// Takes one register write per transaction; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module stc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	stc_cfg_if.sink           cfg,
	output stc_pkg::stc_cfg_t regs
);

	stc_pkg::stc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.quiet_start     <= stc_pkg::TimeW'(2000);
			regs_q.quiet_end       <= stc_pkg::TimeW'(600);
			regs_q.lamp_start      <= stc_pkg::TimeW'(2000);
			regs_q.lamp_end        <= stc_pkg::TimeW'(700);
			regs_q.cool_setpoint   <= stc_pkg::TempW'(400);
			regs_q.cool_hysteresis <= stc_pkg::ByteW'(5);
			regs_q.lockout_seconds <= stc_pkg::ByteW'(20);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				stc_pkg::REG_QUIET_START:     regs_q.quiet_start     <= cfg.data;
				stc_pkg::REG_QUIET_END:       regs_q.quiet_end       <= cfg.data;
				stc_pkg::REG_LAMP_START:      regs_q.lamp_start      <= cfg.data;
				stc_pkg::REG_LAMP_END:        regs_q.lamp_end        <= cfg.data;
				stc_pkg::REG_COOL_SETPOINT:   regs_q.cool_setpoint   <= cfg.data;
				stc_pkg::REG_COOL_HYSTERESIS: regs_q.cool_hysteresis <= cfg.data[stc_pkg::ByteW-1:0];
				stc_pkg::REG_LOCKOUT_SECONDS: regs_q.lockout_seconds <= cfg.data[stc_pkg::ByteW-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/stc_update.sv =====
// ----------------------------------------------------------------------------
// stc_update: next-state logic of the thermostat
// Applies one tick or one sample to the current flags and lockout counter.
// ----------------------------------------------------------------------------
module stc_update (
	input  stc_pkg::stc_cfg_t   regs,
	input  stc_pkg::stc_item_t  item,
	input  stc_pkg::stc_state_t cur,
	output stc_pkg::stc_state_t nxt
);

	logic                                  in_quiet;
	logic                                  in_lamp;
	logic                                  too_warm;
	logic                                  cool_enough;
	logic signed [stc_pkg::CmpW-1:0]       off_level;
	logic signed [stc_pkg::CmpW-1:0]       temp_ext;

	assign in_quiet  = stc_pkg::in_window(regs.quiet_start, regs.quiet_end, item.now);
	assign in_lamp   = stc_pkg::in_window(regs.lamp_start, regs.lamp_end, item.now);
	assign temp_ext  = stc_pkg::CmpW'(item.temp);
	assign off_level = stc_pkg::CmpW'(regs.cool_setpoint)
		- $signed({{(stc_pkg::CmpW-stc_pkg::ByteW){1'b0}}, regs.cool_hysteresis});
	assign too_warm    = item.temp > regs.cool_setpoint;
	assign cool_enough = temp_ext < off_level;

	always_comb begin
		nxt = cur;
		if (!item.is_sample) begin
			if (cur.lockout != '0) begin
				nxt.lockout = cur.lockout - stc_pkg::ByteW'(1);
			end
		end else begin
			if (in_quiet) begin
				nxt.quiet  = 1'b1;
				nxt.cooler = 1'b0;
			end else begin
				nxt.quiet = 1'b0;
				// A switch in either direction needs an expired lockout and rearms it.
				if (!cur.cooler && too_warm) begin
					if (cur.lockout == '0) begin
						nxt.lockout = regs.lockout_seconds;
						nxt.cooler  = 1'b1;
					end
				end else if (cur.cooler && cool_enough) begin
					if (cur.lockout == '0) begin
						nxt.lockout = regs.lockout_seconds;
						nxt.cooler  = 1'b0;
					end
				end
			end
			nxt.light = in_lamp;
		end
	end

endmodule

// ===== rtl/core/scheduled_thermostat_with_lockout.sv =====
// ----------------------------------------------------------------------------
// scheduled_thermostat_with_lockout: cooler and light controller
// Drives a cooler from a hysteresis thermostat with a switch lockout and a
// quiet window, and a light from its own time window.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Transaction carries
//  --------+--------+------------------------------------------------------
//  req     | sink   | req_type, hour_now, minute_now, temp_now
//  res     | source | quiet_active, cooler_on, light_on
//  cfg     | sink   | index, data (one register write)
//
// Every request yields exactly one result. A request is captured in the input
// stage, where the time of day is folded into hhmm form; the flag update then
// runs on it and writes both the state and the result register. One request
// is taken in every cycle while the result side does not stall.
// arst_n clears the state to cooler off, quiet on, light off, lockout zero,
// and loads the register defaults. A stalled result holds the input stage,
// which then holds req.ready low; the configuration channel never stalls.
// ----------------------------------------------------------------------------
module scheduled_thermostat_with_lockout (
	input  logic     clk,
	input  logic     arst_n,
	stc_req_if.sink  req,
	stc_res_if.source res,
	stc_cfg_if.sink  cfg
);

	stc_pkg::stc_cfg_t   regs;
	stc_pkg::stc_item_t  item_s1;
	stc_pkg::stc_state_t state_q;
	stc_pkg::stc_state_t state_nxt;
	logic                valid_s1;
	logic                advance;
	logic                res_valid_q;
	logic                quiet_q;
	logic                cooler_q;
	logic                light_q;
	logic [stc_pkg::TimeW-1:0] now_d;

	// Configuration registers.
	stc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The item in the input stage moves on when the result register is free or
	// is being emptied in this cycle.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	// hour*100 + minute; the largest possible value (3163) fits in 12 bits.
	assign now_d = stc_pkg::TimeW'(req.hour_now) * stc_pkg::HOUR_SCALE
		+ stc_pkg::TimeW'(req.minute_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.is_sample <= req.req_type;
			item_s1.now       <= now_d;
			item_s1.temp      <= req.temp_now;
		end
	end

	// Flag and lockout update for the item in the input stage.
	stc_update u_update (
		.regs (regs),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// The state is committed together with the result, so the next item sees
	// the flags this one leaves behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cooler  <= 1'b0;
			state_q.quiet   <= 1'b1;
			state_q.light   <= 1'b0;
			state_q.lockout <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quiet_q  <= state_nxt.quiet;
			cooler_q <= state_nxt.cooler;
			light_q  <= state_nxt.light;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.quiet_active = quiet_q;
	assign res.cooler_on    = cooler_q;
	assign res.light_on     = light_q;

	// The quiet window always leaves the cooler off.
	a_quiet_forces_off: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.quiet |-> !state_q.cooler)
		else $error("cooler on inside quiet window");

	// The cooler only turns on once the lockout has run out.
	a_on_needs_lockout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.cooler && !$past(state_q.cooler)) |-> ($past(state_q.lockout) == '0))
		else $error("cooler switched on during lockout");

	// The lockout only rises by a reload to the programmed value.
	a_lockout_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.lockout > $past(state_q.lockout)) |->
		(state_q.lockout == regs.lockout_seconds))
		else $error("lockout rose to an unexpected value");

	// A new result only appears when an item left the input stage.
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result without an item");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the scheduled thermostat with lockout
// A directed table covers reset state, window edges, lockout hold, forced off
// in the quiet window and register extremes. Random phases follow, each with
// fresh settings. Each result is checked against a typed row or the predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stc_pkg::*;

	// Request kinds carried by req_type.
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// An index with no register behind it; the block must drop such a write.
	localparam logic [IdxW-1:0] REG_NONE = 3'd7;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 122;
	localparam int DRAIN_CYCLES    = 4;
	localparam int CYCLE_LIMIT     = 400000;

	// Flags of one result, in the order quiet, cooler, light.
	typedef struct packed {
		logic quiet;
		logic cooler;
		logic light;
	} flags_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_SAMPLE} row_kind_t;

	// One line of the directed table. Rows with typed set carry a result that
	// can be read straight off the rules; the others rely on the predictor.
	typedef struct {
		row_kind_t               kind;
		logic [IdxW-1:0]         idx;
		logic [DataW-1:0]        data;
		logic [HourW-1:0]        hr;
		logic [MinW-1:0]         mn;
		logic signed [TempW-1:0] tmp;
		logic                    typed;
		flags_t                  want;
	} row_t;

	logic clk;
	logic arst_n;

	stc_req_if req_ch ();
	stc_res_if res_ch ();
	stc_cfg_if cfg_ch ();

	scheduled_thermostat_with_lockout dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the register file.
	logic [TimeW-1:0]        qs_c, qe_c, ls_c, le_c;
	logic signed [TempW-1:0] set_c;
	logic [ByteW-1:0]        hyst_c, reload_c;

	// Predictor copy of the block state.
	logic             cooler_f, quiet_f, light_f;
	logic [ByteW-1:0] lock_cnt;

	// Flags expected from the block, oldest first.
	flags_t flags_due[$];

	// Side band from the driver to the monitor: a typed result for this row.
	logic   row_typed;
	flags_t row_want;

	// While set, neither side inserts idle cycles.
	logic steady_spell;

	row_t plan[$];

	int n_errors, n_results, n_samples, n_ticks, n_writes, n_switch, n_held;
	int cycles;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Half-open window [s,e) on hhmm values; it wraps past midnight when s > e
	// and never matches when s == e.
	function automatic logic span_covers(int s, int e, int t);
		if (s < e) begin
			return (t >= s) && (t < e);
		end else if (s > e) begin
			return (t >= s) || (t < e);
		end
		return 1'b0;
	endfunction

	// Applies one request to the predictor state and returns the flags that
	// the block must report for it.
	function automatic flags_t advance_thermostat(logic kind, logic [HourW-1:0] hr,
		logic [MinW-1:0] mn, logic signed [TempW-1:0] tmp);
		int     hhmm;
		int     low_mark;
		flags_t f;
		if (kind == REQ_TICK) begin
			// A tick only counts the lockout down; time and temperature are ignored.
			if (lock_cnt != 0) begin
				lock_cnt = lock_cnt - 1'b1;
			end
		end else begin
			// Out-of-range hours and minutes are folded as they are, no wrapping.
			hhmm = int'(hr) * 100 + int'(mn);
			low_mark = int'(set_c) - int'(hyst_c);
			if (span_covers(int'(qs_c), int'(qe_c), hhmm)) begin
				// The quiet window turns the cooler off at once and leaves the
				// lockout counter alone.
				quiet_f = 1'b1;
				cooler_f = 1'b0;
			end else begin
				quiet_f = 1'b0;
				if (!cooler_f && tmp > set_c) begin
					if (lock_cnt == 0) begin
						lock_cnt = reload_c;
						cooler_f = 1'b1;
						n_switch++;
					end else begin
						n_held++;
					end
				end else if (cooler_f && int'(tmp) < low_mark) begin
					if (lock_cnt == 0) begin
						lock_cnt = reload_c;
						cooler_f = 1'b0;
						n_switch++;
					end else begin
						n_held++;
					end
				end
			end
			light_f = span_covers(int'(ls_c), int'(le_c), hhmm);
		end
		f.quiet = quiet_f;
		f.cooler = cooler_f;
		f.light = light_f;
		return f;
	endfunction

	task automatic report_field(string name, logic want, logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
			n_errors++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. A register write
	// updates the predictor, an accepted request pushes its expected flags and
	// an accepted result is checked against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		flags_t want;
		flags_t got;
		flags_t pred;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_QUIET_START:     qs_c = cfg_ch.data;
					REG_QUIET_END:       qe_c = cfg_ch.data;
					REG_LAMP_START:      ls_c = cfg_ch.data;
					REG_LAMP_END:        le_c = cfg_ch.data;
					REG_COOL_SETPOINT:   set_c = cfg_ch.data;
					REG_COOL_HYSTERESIS: hyst_c = cfg_ch.data[ByteW-1:0];
					REG_LOCKOUT_SECONDS: reload_c = cfg_ch.data[ByteW-1:0];
					default: ;
				endcase
				n_writes++;
			end
			// Results are checked before the new request is queued, so a result
			// can never be matched against a request of the same cycle.
			if (res_ch.valid && res_ch.ready) begin
				got.quiet = res_ch.quiet_active;
				got.cooler = res_ch.cooler_on;
				got.light = res_ch.light_on;
				if (flags_due.size() == 0) begin
					$display("%0t: result with nothing expected, got quiet=%b cooler=%b light=%b",
						$time, got.quiet, got.cooler, got.light);
					n_errors++;
				end else begin
					want = flags_due.pop_front();
					report_field("quiet_active", want.quiet, got.quiet);
					report_field("cooler_on", want.cooler, got.cooler);
					report_field("light_on", want.light, got.light);
					n_results++;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				pred = advance_thermostat(req_ch.req_type, req_ch.hour_now,
					req_ch.minute_now, req_ch.temp_now);
				flags_due.push_back(row_typed ? row_want : pred);
				if (req_ch.req_type == REQ_TICK) begin
					n_ticks++;
				end else begin
					n_samples++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Clock, watchdog and idle pattern
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Now and then the bench enters a spell with no idle cycles on either side.
	initial begin
		steady_spell = 1'b0;
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			steady_spell = ($urandom_range(0, 3) == 0);
		end
	end

	// Idle length in cycles: mostly none or short, sometimes long.
	function automatic int pause_len();
		int r;
		if (steady_spell) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Result side: bursts of ready followed by stalls of random length.
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			res_ch.ready = 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			n = pause_len();
			if (n > 0) begin
				res_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks; all of them start and end at a falling edge.
	// ------------------------------------------------------------------------

	// Offers one request and returns once it has been accepted. valid stays
	// high when the next request follows without a gap.
	task automatic send_item(logic kind, logic [HourW-1:0] hr, logic [MinW-1:0] mn,
		logic signed [TempW-1:0] tmp, logic typed, flags_t want);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = kind;
		req_ch.hour_now = hr;
		req_ch.minute_now = mn;
		req_ch.temp_now = tmp;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Waits until every expected result has come back and the pipeline has
	// had time to empty, so that a register write lands on an idle block.
	task automatic settle();
		req_ch.valid = 1'b0;
		while (flags_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
		settle();
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------------
	function automatic row_t wr(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
		row_t r;
		r = '{kind: ROW_WRITE, idx: idx, data: data, hr: '0, mn: '0, tmp: '0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	// Ticks carry all-ones time and temperature to show they are ignored.
	function automatic row_t tk(logic typed, flags_t want);
		row_t r;
		r = '{kind: ROW_TICK, idx: '0, data: '0, hr: '1, mn: '1, tmp: -12'sd1,
			typed: typed, want: want};
		return r;
	endfunction

	function automatic row_t sm(int hr, int mn, int tmp, logic typed, flags_t want);
		row_t r;
		r = '{kind: ROW_SAMPLE, idx: '0, data: '0, hr: hr[HourW-1:0], mn: mn[MinW-1:0],
			tmp: tmp[TempW-1:0], typed: typed, want: want};
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [TimeW-1:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return TimeW'($urandom_range(0, 2359));
		end else if (r < 90) begin
			return TimeW'($urandom_range(0, 4095));
		end else if (r < 95) begin
			return '0;
		end
		return TimeW'(2359);
	endfunction

	function automatic int pick_setpoint();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return int'($urandom_range(0, 2880)) - 880;
		end else if (r < 90) begin
			return int'($urandom_range(0, 4095)) - 2048;
		end else if (r < 95) begin
			return -2048;
		end
		return 2047;
	endfunction

	// Temperatures cluster around the two switch points so that the cooler
	// really toggles; the rest spread over the whole 12-bit range.
	function automatic logic signed [TempW-1:0] pick_temp(int setp, int hyst);
		int r;
		int t;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			t = setp + int'($urandom_range(0, 20)) - 10;
		end else if (r < 65) begin
			t = setp - hyst + int'($urandom_range(0, 20)) - 10;
		end else begin
			t = int'($urandom_range(0, 4095)) - 2048;
		end
		if (t > 2047) begin
			t = 2047;
		end else if (t < -2048) begin
			t = -2048;
		end
		return t[TempW-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int               setp;
		int               hyst;
		int               q_start;
		logic [HourW-1:0] hr;
		logic [MinW-1:0]  mn;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.hour_now = '0;
		req_ch.minute_now = '0;
		req_ch.temp_now = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		row_typed = 1'b0;
		row_want = '0;
		n_errors = 0;
		n_results = 0;
		n_samples = 0;
		n_ticks = 0;
		n_writes = 0;
		n_switch = 0;
		n_held = 0;

		// Predictor starts from the reset state of the block.
		qs_c = TimeW'(2000);
		qe_c = TimeW'(600);
		ls_c = TimeW'(2000);
		le_c = TimeW'(700);
		set_c = 12'sd400;
		hyst_c = 8'd5;
		reload_c = 8'd20;
		cooler_f = 1'b0;
		quiet_f = 1'b1;
		light_f = 1'b0;
		lock_cnt = '0;

		// Directed table. Typed results are written {quiet, cooler, light}.
		// A short lockout first, then the default windows (quiet 2000-0600,
		// light 2000-0700) and setpoint 400 with margin 5.
		plan.push_back(wr(REG_LOCKOUT_SECONDS, DataW'(2)));
		plan.push_back(tk(1'b1, 3'b100));               // reset flags as they stand
		plan.push_back(sm(12, 0, 2047, 1'b1, 3'b010));  // hottest reading switches on
		plan.push_back(sm(12, 1, -2048, 1'b1, 3'b010)); // coldest, but lockout holds
		plan.push_back(sm(21, 0, 2047, 1'b1, 3'b101));  // quiet forces off despite lockout
		plan.push_back(tk(1'b1, 3'b101));
		plan.push_back(tk(1'b1, 3'b101));
		plan.push_back(sm(6, 0, 2047, 1'b1, 3'b011));   // quiet end is exclusive
		plan.push_back(tk(1'b1, 3'b011));
		plan.push_back(tk(1'b1, 3'b011));
		plan.push_back(sm(7, 0, -2048, 1'b1, 3'b000));  // light end is exclusive
		plan.push_back(sm(31, 63, 400, 1'b1, 3'b101));  // out-of-range time, no wrap
		plan.push_back(sm(0, 63, 400, 1'b1, 3'b101));
		// Register extremes: empty quiet window, light window that never
		// matches, top setpoint and margin, zero reload, and a dead index.
		plan.push_back(wr(REG_QUIET_START, '0));
		plan.push_back(wr(REG_QUIET_END, '0));
		plan.push_back(wr(REG_LAMP_START, '1));
		plan.push_back(wr(REG_LAMP_END, '0));
		plan.push_back(wr(REG_COOL_SETPOINT, 12'h7FF));
		plan.push_back(wr(REG_COOL_HYSTERESIS, 12'h0FF));
		plan.push_back(wr(REG_LOCKOUT_SECONDS, '0));
		plan.push_back(wr(REG_NONE, '1));
		plan.push_back(tk(1'b0, '0));
		plan.push_back(tk(1'b0, '0));
		plan.push_back(sm(19, 59, 2047, 1'b0, '0));
		plan.push_back(sm(23, 59, -2048, 1'b0, '0));
		plan.push_back(wr(REG_COOL_SETPOINT, 12'h800));
		plan.push_back(sm(0, 0, -2047, 1'b0, '0));
		plan.push_back(sm(10, 30, -2048, 1'b0, '0));
		// Zero setpoint, zero margin and zero reload: the cooler may flip on
		// every sample.
		plan.push_back(wr(REG_COOL_SETPOINT, '0));
		plan.push_back(wr(REG_COOL_HYSTERESIS, '0));
		plan.push_back(sm(12, 0, -1, 1'b0, '0));
		plan.push_back(sm(12, 0, 1, 1'b0, '0));
		plan.push_back(sm(12, 0, 0, 1'b0, '0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_WRITE) begin
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				send_item(plan[k].kind == ROW_SAMPLE ? REQ_SAMPLE : REQ_TICK, plan[k].hr,
					plan[k].mn, plan[k].tmp, plan[k].typed, plan[k].want);
			end
		end

		// Random phases, each with its own register settings. The last one
		// uses the longest lockout so that switches are held back for good.
		for (int p = 0; p < PHASES; p++) begin
			setp = pick_setpoint();
			hyst = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 255);
			q_start = int'(pick_time());
			write_reg(REG_QUIET_START, q_start[TimeW-1:0]);
			write_reg(REG_QUIET_END,
				($urandom_range(0, 9) == 0) ? q_start[TimeW-1:0] : pick_time());
			write_reg(REG_LAMP_START, pick_time());
			write_reg(REG_LAMP_END, pick_time());
			write_reg(REG_COOL_SETPOINT, setp[DataW-1:0]);
			// Upper data bits above the 8-bit registers must be dropped.
			write_reg(REG_COOL_HYSTERESIS, {4'($urandom_range(0, 15)), 8'(hyst)});
			if (p == PHASES - 1) begin
				write_reg(REG_LOCKOUT_SECONDS, DataW'(255));
			end else if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_LOCKOUT_SECONDS, '0);
			end else begin
				write_reg(REG_LOCKOUT_SECONDS, DataW'($urandom_range(1, 8)));
			end
			write_reg(REG_NONE, DataW'($urandom_range(0, 4095)));

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				hr = ($urandom_range(0, 6) == 0) ? HourW'($urandom_range(0, 31))
					: HourW'($urandom_range(0, 23));
				mn = ($urandom_range(0, 6) == 0) ? MinW'($urandom_range(0, 63))
					: MinW'($urandom_range(0, 59));
				if ($urandom_range(0, 99) < 35) begin
					// Ticks carry random time and temperature, which must not matter.
					send_item(REQ_TICK, hr, mn, TempW'($urandom_range(0, 4095)), 1'b0, '0);
				end else begin
					send_item(REQ_SAMPLE, hr, mn, pick_temp(setp, hyst), 1'b0, '0);
				end
			end
		end

		// Let the last results come back, then keep watching for anything that
		// should not be there.
		settle();
		repeat (8) @(posedge clk);

		$display("Run covered %0d transactions (%0d samples, %0d ticks) and %0d register writes.",
			n_results, n_samples, n_ticks, n_writes);
		$display("The cooler switched %0d times and the lockout held it back %0d times.",
			n_switch, n_held);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches seen", n_errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/stc_pkg.sv
rtl/core/stc_ifs.sv
rtl/core/stc_cfg_regs.sv
rtl/core/stc_update.sv
rtl/core/scheduled_thermostat_with_lockout.sv
tb/tb.sv
